// ----- rtl/obwtp_pkg.sv -----
// ----------------------------------------------------------------------------
// obwtp_pkg: shared types and constants of the weighted top price book
// Entry, cell control and sequencer types, mode and status codes.
// ----------------------------------------------------------------------------
package obwtp_pkg;

	localparam int MAX_ORDERS_DEF = 64;

	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_ERASE   = 2'd1;
	localparam logic [1:0] MODE_ADVANCE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [48:0] TIME_MAX   = 49'h0_FFFF_FFFF_FFFF;
	localparam logic [64:0] WEIGHT_MAX = 65'h0_000F_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        valid;
		logic [31:0] id;
		logic [31:0] price;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     take_next;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REMOVE,
		S_INSERT,
		S_SEG,
		S_MUL,
		S_ACC
	} state_t;

endpackage

// ----- rtl/obwtp_cell.sv -----
// ----------------------------------------------------------------------------
// obwtp_cell: one slot of the price-sorted order chain
// Holds one order, compares it with the request key and takes its content
// from a neighbor or from the key when the chain shifts.
// ----------------------------------------------------------------------------
module obwtp_cell
	import obwtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  logic [31:0] key_id,
	input  logic [31:0] key_price,
	input  entry_t      prev_ent,
	input  logic        prev_gt,
	input  entry_t      next_ent,
	output entry_t      ent,
	output logic        match,
	output logic        gt
);

	logic        valid_q;
	logic [31:0] id_q;
	logic [31:0] price_q;
	entry_t      ent_d;

	assign ent   = '{valid: valid_q, id: id_q, price: price_q};
	assign match = valid_q && (id_q == key_id);
	// The chain is sorted by falling price, so gt is low at the head and
	// high from the insert position on.
	assign gt    = !valid_q || (key_price > price_q);

	always_comb begin
		ent_d = ent;
		case (ctl.op)
			CELL_REMOVE: begin
				if (ctl.take_next) begin
					ent_d = next_ent;
				end
			end
			CELL_INSERT: begin
				if (gt) begin
					if (prev_gt) begin
						ent_d = prev_ent;
					end else begin
						ent_d = '{valid: 1'b1, id: key_id, price: key_price};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q    <= ent_d.id;
		price_q <= ent_d.price;
	end

endmodule

// ----- rtl/order_book_weighted_top_price.sv -----
// ----------------------------------------------------------------------------
// order_book_weighted_top_price: order book with time-weighted top price
// Price-sorted chain of order cells plus segment and running sum logic.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low;
// mode, timestamp, order_id and price are sampled at that edge. busy then
// stays high through five steps: one removes a matching order from the
// chain (erase, or re-insert of a live id), one inserts the new order at
// its sorted place, one reads the head cell as top price and closes a
// segment, one multiplies duration by price, one updates the saturating
// sums. In the cycle after that done is high for exactly one cycle with
// all result ports valid; the receiver cannot stall and must take it then.
// A new request may be started in the done cycle; the five-step sequencer
// around the cell chain takes no new request until it is back in idle.
// The chain has MAX_ORDERS cells kept in falling price order; the head cell
// always holds the top price, and all cells shift in parallel.
// Reset empties the book, clears the previous top, time and both sums, and
// returns the sequencer to idle. The segment, top and status ports hold their last values.
// ----------------------------------------------------------------------------
module order_book_weighted_top_price
	import obwtp_pkg::*;
#(
	parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] timestamp,
	input  logic [31:0] order_id,
	input  logic [31:0] price,
	output logic        done,
	output logic        seg_valid,
	output logic [31:0] seg_start,
	output logic [31:0] seg_end,
	output logic [31:0] seg_price,
	output logic        top_valid,
	output logic [31:0] top_price,
	output logic [47:0] sum_time,
	output logic [51:0] sum_weighted,
	output logic [1:0]  status
);

	localparam int LVL = $clog2(MAX_ORDERS);

	state_t      state_q, state_d;
	cell_op_t    cell_op;
	logic [1:0]  mode_q;
	logic [31:0] ts_q, id_q, price_q;
	logic        hit_q;
	logic [1:0]  status_q;

	entry_t          ents   [MAX_ORDERS];
	entry_t          prev_e [MAX_ORDERS];
	entry_t          next_e [MAX_ORDERS];
	logic [MAX_ORDERS-1:0] prev_g;
	logic [MAX_ORDERS-1:0] match_v;
	logic [MAX_ORDERS-1:0] gt_v;
	logic [MAX_ORDERS-1:0] pre [LVL+1];

	logic        prev_top_valid_q;
	logic [31:0] prev_top_price_q;
	logic [31:0] prev_time_q;
	logic        close_q;
	logic [31:0] dur_q;
	logic [31:0] seg_start_q, seg_end_q, seg_price_q;
	logic        top_valid_q;
	logic [31:0] top_price_q;
	logic [63:0] prod_q;
	logic [47:0] total_time_q;
	logic [51:0] total_weighted_q;
	logic        done_q;
	logic        out_seg_valid_q;
	logic [31:0] out_seg_start_q, out_seg_end_q, out_seg_price_q;
	logic        out_top_valid_q;
	logic [31:0] out_top_price_q;
	logic [1:0]  out_status_q;

	logic        book_full;
	logic        cur_valid;
	logic [31:0] cur_price;
	logic        close_now;
	logic [48:0] time_sum;
	logic [64:0] weight_sum;

	// ---------------- cell chain ----------------
	// Prefix OR of the match vector marks every cell at or below the match;
	// those cells pull their content up by one on removal.
	assign pre[0] = match_v;
	for (genvar l = 0; l < LVL; l++) begin : g_lvl
		for (genvar j = 0; j < MAX_ORDERS; j++) begin : g_bit
			if (j >= (1 << l)) begin : g_or
				assign pre[l+1][j] = pre[l][j] | pre[l][j-(1<<l)];
			end else begin : g_pass
				assign pre[l+1][j] = pre[l][j];
			end
		end
	end

	for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
		cell_ctl_t ctl;

		assign ctl.op        = cell_op;
		assign ctl.take_next = pre[LVL][i];

		if (i == 0) begin : g_head
			assign prev_e[i] = '0;
			assign prev_g[i] = 1'b0;
		end else begin : g_body
			assign prev_e[i] = ents[i-1];
			assign prev_g[i] = gt_v[i-1];
		end
		if (i == MAX_ORDERS - 1) begin : g_tail
			assign next_e[i] = '0;
		end else begin : g_mid
			assign next_e[i] = ents[i+1];
		end

		obwtp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_id    (id_q),
			.key_price (price_q),
			.prev_ent  (prev_e[i]),
			.prev_gt   (prev_g[i]),
			.next_ent  (next_e[i]),
			.ent       (ents[i]),
			.match     (match_v[i]),
			.gt        (gt_v[i])
		);
	end

	assign book_full = ents[MAX_ORDERS-1].valid;
	assign cur_valid = ents[0].valid;
	assign cur_price = ents[0].valid ? ents[0].price : 32'd0;
	assign close_now = prev_top_valid_q && (!cur_valid || (cur_price != prev_top_price_q));

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (start) state_d = S_REMOVE;
			S_REMOVE: state_d = S_INSERT;
			S_INSERT: state_d = S_SEG;
			S_SEG:    state_d = S_MUL;
			S_MUL:    state_d = S_ACC;
			S_ACC:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		cell_op = CELL_HOLD;
		case (state_q)
			S_IDLE: busy = 1'b0;
			S_REMOVE: begin
				if (mode_q == MODE_INSERT || mode_q == MODE_ERASE) begin
					cell_op = CELL_REMOVE;
				end
			end
			S_INSERT: begin
				if (mode_q == MODE_INSERT && !book_full) begin
					cell_op = CELL_INSERT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_ACC);
		end
	end

	// ---------------- request capture and status ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q  <= mode;
			ts_q    <= timestamp;
			id_q    <= order_id;
			price_q <= price;
		end
		if (state_q == S_REMOVE) begin
			hit_q <= |match_v;
		end
		if (state_q == S_INSERT) begin
			if (mode_q == MODE_ERASE && !hit_q) begin
				status_q <= ST_ABSENT;
			end else if (mode_q == MODE_INSERT && book_full) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	// ---------------- segment, product, sums ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_top_valid_q <= 1'b0;
			prev_top_price_q <= '0;
			prev_time_q      <= '0;
		end else if (state_q == S_SEG && (close_now || !prev_top_valid_q)) begin
			prev_top_valid_q <= cur_valid;
			prev_top_price_q <= cur_price;
			prev_time_q      <= ts_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEG) begin
			close_q     <= close_now;
			dur_q       <= (ts_q >= prev_time_q) ? (ts_q - prev_time_q) : 32'd0;
			seg_start_q <= prev_time_q;
			seg_end_q   <= ts_q;
			seg_price_q <= prev_top_price_q;
			top_valid_q <= cur_valid;
			top_price_q <= cur_price;
		end
		if (state_q == S_MUL) begin
			prod_q <= 64'(dur_q) * 64'(seg_price_q);
		end
	end

	assign time_sum   = {1'b0, total_time_q} + 49'(dur_q);
	assign weight_sum = 65'(total_weighted_q) + 65'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q     <= '0;
			total_weighted_q <= '0;
		end else if (state_q == S_ACC && close_q) begin
			total_time_q     <= (time_sum > TIME_MAX) ? TIME_MAX[47:0] : time_sum[47:0];
			total_weighted_q <= (weight_sum > WEIGHT_MAX) ? WEIGHT_MAX[51:0] : weight_sum[51:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACC) begin
			out_seg_valid_q <= close_q;
			out_seg_start_q <= close_q ? seg_start_q : 32'd0;
			out_seg_end_q   <= close_q ? seg_end_q : 32'd0;
			out_seg_price_q <= close_q ? seg_price_q : 32'd0;
			out_top_valid_q <= top_valid_q;
			out_top_price_q <= top_price_q;
			out_status_q    <= status_q;
		end
	end

	assign done         = done_q;
	assign seg_valid    = out_seg_valid_q;
	assign seg_start    = out_seg_start_q;
	assign seg_end      = out_seg_end_q;
	assign seg_price    = out_seg_price_q;
	assign top_valid    = out_top_valid_q;
	assign top_price    = out_top_price_q;
	assign sum_time     = total_time_q;
	assign sum_weighted = total_weighted_q;
	assign status       = out_status_q;

endmodule

// ----- tb/sv/order_book_weighted_top_price_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_book_weighted_top_price_tb: self-checking bench for the top price book
// Drives insert, erase and time-only requests, predicts the top price, closed
// segments and saturating sums, and checks every done strobe against that.
// ----------------------------------------------------------------------------
module order_book_weighted_top_price_tb
	import obwtp_pkg::*;
();

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         POOL_SIZE    = 72;
	localparam int         RANDOM_ITEMS = 730;
	localparam int         BLOCK_LEN    = 60;

	typedef struct packed {
		logic        seg_valid;
		logic [31:0] seg_start;
		logic [31:0] seg_end;
		logic [31:0] seg_price;
		logic        top_valid;
		logic [31:0] top_price;
		logic [47:0] sum_time;
		logic [51:0] sum_weighted;
		logic [1:0]  status;
	} book_result_t;

	typedef enum {TR_FILL, TR_DRAIN, TR_MIXED} traffic_t;

	// Tracks the live orders, the previous top and the running sums, and
	// holds the results that the block still owes.
	class top_price_book;
		bit           cell_live [MAX_ORDERS_DEF];
		logic [31:0]  cell_id [MAX_ORDERS_DEF];
		logic [31:0]  cell_px [MAX_ORDERS_DEF];
		bit           last_valid;
		logic [31:0]  last_price;
		logic [31:0]  last_time;
		logic [63:0]  time_sum;
		logic [63:0]  weight_sum;
		book_result_t owed_results [$];
		int unsigned  failures;

		function new();
			foreach (cell_live[i]) begin
				cell_live[i] = 1'b0;
				cell_id[i] = '0;
				cell_px[i] = '0;
			end
			last_valid = 1'b0;
			last_price = '0;
			last_time = '0;
			time_sum = '0;
			weight_sum = '0;
			failures = 0;
		endfunction

		function int find_order(logic [31:0] id);
			foreach (cell_live[i])
				if (cell_live[i] && cell_id[i] == id)
					return i;
			return -1;
		endfunction

		function int find_free();
			foreach (cell_live[i])
				if (!cell_live[i])
					return i;
			return -1;
		endfunction

		function bit holds(logic [31:0] id);
			return find_order(id) >= 0;
		endfunction

		function bit first_live(output logic [31:0] id);
			id = '0;
			foreach (cell_live[i])
				if (cell_live[i]) begin
					id = cell_id[i];
					return 1'b1;
				end
			return 1'b0;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		function logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] add, logic [63:0] ceil);
			if (add > ceil || acc > ceil - add)
				return ceil;
			return acc + add;
		endfunction

		function void note_request(logic [1:0] m, logic [31:0] ts, logic [31:0] id,
				logic [31:0] px);
			book_result_t r;
			int           slot;
			bit           top_ok;
			logic [31:0]  top;
			logic [63:0]  dur;
			r = '0;
			r.status = ST_OK;
			top_ok = 1'b0;
			top = '0;
			if (m == MODE_INSERT) begin
				slot = find_order(id);
				if (slot < 0)
					slot = find_free();
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					cell_live[slot] = 1'b1;
					cell_id[slot] = id;
					cell_px[slot] = px;
				end
			end else if (m == MODE_ERASE) begin
				slot = find_order(id);
				if (slot < 0)
					r.status = ST_ABSENT;
				else
					cell_live[slot] = 1'b0;
			end
			foreach (cell_live[i])
				if (cell_live[i] && (!top_ok || cell_px[i] > top)) begin
					top_ok = 1'b1;
					top = cell_px[i];
				end
			if (!last_valid || !top_ok || top != last_price) begin
				if (last_valid) begin
					// A clock running backwards closes the segment with no duration.
					dur = (ts >= last_time) ? {32'd0, ts - last_time} : 64'd0;
					r.seg_valid = 1'b1;
					r.seg_start = last_time;
					r.seg_end = ts;
					r.seg_price = last_price;
					time_sum = sat_sum(time_sum, dur, 64'(TIME_MAX));
					weight_sum = sat_sum(weight_sum, dur * {32'd0, last_price},
						64'(WEIGHT_MAX));
				end
				last_valid = top_ok;
				last_price = top_ok ? top : 32'd0;
				last_time = ts;
			end
			r.top_valid = top_ok;
			r.top_price = top_ok ? top : 32'd0;
			r.sum_time = time_sum[47:0];
			r.sum_weighted = weight_sum[51:0];
			owed_results.insert(owed_results.size(), r);
		endfunction

		function void show(string tag, book_result_t r);
			$display("  %s: seg=%0b %08h..%08h @%08h top=%0b %08h time=%012h wsum=%013h st=%0d",
				tag, r.seg_valid, r.seg_start, r.seg_end, r.seg_price, r.top_valid,
				r.top_price, r.sum_time, r.sum_weighted, r.status);
		endfunction

		function void check_result(book_result_t got);
			book_result_t want;
			if (owed_results.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result with no request outstanding", $realtime);
					show("got", got);
				end
				return;
			end
			want = owed_results.pop_front();
			if (got.seg_valid !== want.seg_valid || got.seg_start !== want.seg_start ||
					got.seg_end !== want.seg_end || got.seg_price !== want.seg_price ||
					got.top_valid !== want.top_valid || got.top_price !== want.top_price ||
					got.sum_time !== want.sum_time || got.sum_weighted !== want.sum_weighted ||
					got.status !== want.status) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result mismatch", $realtime);
					show("exp", want);
					show("got", got);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_ADVANCE;
	logic [31:0] timestamp = '0;
	logic [31:0] order_id = '0;
	logic [31:0] price = '0;
	logic        busy;
	logic        done;
	logic        seg_valid;
	logic [31:0] seg_start;
	logic [31:0] seg_end;
	logic [31:0] seg_price;
	logic        top_valid;
	logic [31:0] top_price;
	logic [47:0] sum_time;
	logic [51:0] sum_weighted;
	logic [1:0]  status;

	top_price_book book = new();
	bit            idle_enable = 1'b1;
	logic [31:0]   now_ts = '0;
	logic [31:0]   id_pool [POOL_SIZE];
	logic [31:0]   price_picks [8] = '{32'h0, 32'h1, 32'h0001_0000, 32'h8000_0000,
		32'hFFFF_FFFF, 32'h0064_0000, 32'h1234_0000, 32'h0001_8000};

	order_book_weighted_top_price u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.timestamp    (timestamp),
		.order_id     (order_id),
		.price        (price),
		.done         (done),
		.seg_valid    (seg_valid),
		.seg_start    (seg_start),
		.seg_end      (seg_end),
		.seg_price    (seg_price),
		.top_valid    (top_valid),
		.top_price    (top_price),
		.sum_time     (sum_time),
		.sum_weighted (sum_weighted),
		.status       (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_result('{seg_valid, seg_start, seg_end, seg_price, top_valid,
				top_price, sum_time, sum_weighted, status});
	end

	// Offers one request and returns at the edge that takes it.
	task automatic send_request(input logic [1:0] m, input logic [31:0] ts,
			input logic [31:0] id, input logic [31:0] px);
		if (idle_enable && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		timestamp <= ts;
		order_id <= id;
		price <= px;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		book.note_request(m, ts, id, px);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly small steps so the weighted sum stays clear of its ceiling until
	// the closing requests drive it there on purpose.
	function automatic logic [31:0] next_time();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 78)
			now_ts = now_ts + $urandom_range(63);
		else if (roll < 96)
			now_ts = now_ts + $urandom_range(1023);
		else if (roll < 99)
			now_ts = now_ts + $urandom_range(16383);
		else
			now_ts = $urandom_range(now_ts);
		return now_ts;
	endfunction

	function automatic logic [31:0] pick_price();
		if ($urandom_range(1) == 0)
			return price_picks[$urandom_range(7)];
		return $urandom;
	endfunction

	// Draws from the id pool, leaning toward ids that are live or not.
	function automatic logic [31:0] pick_id(bit want_live);
		logic [31:0] cand;
		cand = id_pool[$urandom_range(POOL_SIZE - 1)];
		repeat (8)
			if (book.holds(cand) != want_live)
				cand = id_pool[$urandom_range(POOL_SIZE - 1)];
		return cand;
	endfunction

	initial begin
		traffic_t    plan [4];
		traffic_t    traffic;
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned era_pct;
		logic [31:0] drain_id;
		logic [31:0] ts;

		plan = '{TR_FILL, TR_FILL, TR_DRAIN, TR_MIXED};
		foreach (id_pool[i])
			id_pool[i] = $urandom;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFF;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty book, absent erase, re-insert, unused mode, time going
		// backwards, book emptied, extremes of every field.
		send_request(MODE_ADVANCE, 32'd5, 32'h0, 32'h0);
		send_request(MODE_ERASE, 32'd6, 32'h0, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 32'd9, 32'h0, 32'h0);
		send_request(MODE_SPARE, 32'd12, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(MODE_INSERT, 32'd20, 32'hFFFF_FFFF, 32'h0001_0000);
		send_request(MODE_INSERT, 32'd15, 32'h5A5A_5A5A, 32'h0002_0000);
		send_request(MODE_ERASE, 32'd16, 32'h5A5A_5A5A, 32'h0);
		send_request(MODE_ERASE, 32'd17, 32'h1234_5678, 32'h0);
		send_request(MODE_ERASE, 32'd32, 32'hFFFF_FFFF, 32'h0);
		send_request(MODE_ERASE, 32'd48, 32'h0, 32'h0);
		send_request(MODE_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 32'h0, 32'hA5A5_A5A5, 32'hAAAA_AAAA);
		send_request(MODE_INSERT, 32'd3, 32'h5A5A_5A5A, 32'h5555_5555);
		send_request(MODE_ERASE, 32'd5, 32'hA5A5_A5A5, 32'h0);
		now_ts = 32'd5;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			traffic = plan[(n / BLOCK_LEN) % 4];
			idle_enable = !(n >= 300 && n < 450);
			if (n == 500)
				wait_drained();
			case (traffic)
				TR_FILL: begin
					ins_pct = 70;
					era_pct = 15;
				end
				TR_DRAIN: begin
					ins_pct = 15;
					era_pct = 70;
				end
				default: begin
					ins_pct = 45;
					era_pct = 40;
				end
			endcase
			roll = $urandom_range(99);
			ts = next_time();
			if (roll < ins_pct)
				send_request(MODE_INSERT, ts, pick_id(traffic == TR_DRAIN), pick_price());
			else if (roll < ins_pct + era_pct)
				send_request(MODE_ERASE, ts,
					($urandom_range(4) == 0) ? $urandom : pick_id($urandom_range(9) < 7),
					$urandom);
			else if (roll < 95)
				send_request(MODE_ADVANCE, ts, $urandom, $urandom);
			else
				send_request(MODE_SPARE, ts, $urandom, $urandom);
		end

		wait_drained();
		idle_enable = 1'b1;
		while (book.first_live(drain_id))
			send_request(MODE_ERASE, next_time(), drain_id, $urandom);

		// One long segment at the highest price drives the weighted sum into
		// saturation; the request after it must leave the sum pinned there.
		send_request(MODE_INSERT, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0007);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0009);

		start <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (book.failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#200000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
